// ===== sv/rtcb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtcb_pkg
// Codes, phase constants and BCD helpers for the three-wire RTC access unit.
// ----------------------------------------------------------------------------
package rtcb_pkg;

	// Request codes carried by the mode field
	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// Register indexes of the configuration port
	localparam logic REG_HOUR_ADDRESS = 1'b0;

	localparam logic [7:0] HOUR_ADDRESS_RESET = 8'd132;

	// Pin phases of one transaction
	localparam logic [5:0] PH_IDLE      = 6'd0;
	localparam logic [5:0] PH_START     = 6'd1;
	localparam logic [5:0] PH_ENABLE    = 6'd2;
	localparam logic [5:0] PH_BIT_FIRST = 6'd3;
	localparam logic [5:0] PH_RX_FIRST  = 6'd20;
	localparam logic [5:0] PH_BIT_LAST  = 6'd34;
	localparam logic [5:0] PH_CLK_LOW   = 6'd35;
	localparam logic [5:0] PH_CLK_HIGH  = 6'd36;
	localparam logic [5:0] PH_LAST      = 6'd37;

	// Pin levels as one group
	typedef struct packed {
		logic ce;
		logic sclk;
		logic dout;
		logic drive;
	} pins_t;

	// Decimal to BCD; tens by reciprocal multiply (exact for 0..127)
	function automatic logic [7:0] dec_to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  tens_x10;
		logic [6:0]  ones;
		prod     = {8'd0, v} * 15'd205;
		tens     = prod[14:11];
		tens_x10 = {tens, 3'b000} - {3'b000, tens} - {3'b000, tens} + {2'b00, tens, 1'b0}
			+ {3'b000, tens} + {3'b000, tens};
		ones     = v - tens_x10;
		return {tens, ones[3:0]};
	endfunction

	// BCD to decimal; the hour register keeps the full tens nibble
	function automatic logic [7:0] bcd_to_dec(input logic [7:0] d, input logic hour);
		logic [7:0] tens;
		tens = hour ? {4'd0, d[7:4]} : {5'd0, d[6:4]};
		return (tens << 3) + (tens << 1) + {4'd0, d[3:0]};
	endfunction

endpackage
`default_nettype wire

// ===== sv/rtc_three_wire_bcd_access_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_three_wire_bcd_access_unit
// Master for a three-wire RTC register interface with BCD conversion.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one beat per request or
//   tick: mode 1 starts a write of value to reg_address, mode 2 starts a
//   read from reg_address plus one, mode 0 advances the pins one phase.
//   Every input beat yields exactly one output beat (out_valid/out_ready)
//   holding the pin levels, busy, done, the last read result and the
//   rejected flag. A transaction runs 37 beats from the start request to
//   the beat that drops enable and pulses done.
//   Each output beat is registered and appears in the cycle after its input
//   beat is accepted; throughput is one beat per cycle while the receiver
//   drains the output register. in_ready stays high while the output
//   register is empty or is being drained in the same cycle, so a stalled
//   receiver holds the waiting beat and blocks new input only while it is
//   full.
//   Reset empties the output register, returns the sequencer to idle, clears
//   the shift registers and the last read result, and loads hour_address
//   with 132. hour_address is written on the APB port at byte address 0.
// ----------------------------------------------------------------------------
module rtc_three_wire_bcd_access_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  reg_address,
	input  wire logic [6:0]  value,
	input  wire logic        io_in,
	// Output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             chip_enable,
	output logic             serial_clock,
	output logic             io_out,
	output logic             io_drive,
	output logic             busy_res,
	output logic             done_res,
	output logic      [7:0]  read_value,
	output logic             rejected
);
	import rtcb_pkg::*;

	// Configuration
	logic [7:0]  hour_q;

	// Sequencer state
	logic [5:0]  phase_q,  phase_n;
	logic [15:0] tx_q,     tx_n;
	logic [7:0]  rx_q,     rx_n;
	logic        read_q,   read_n;
	logic        hour_hit_q, hour_hit_n;
	logic [7:0]  last_q,   last_n;

	// Step results
	logic [5:0]  shown;
	logic [5:0]  np;
	logic [5:0]  offs;
	logic [3:0]  bit_idx;
	logic        done_n;
	logic        rej_n;
	pins_t       pins_n;

	// Output register
	logic        out_valid_q;
	pins_t       pins_q;
	logic        busy_q;
	logic        done_q;
	logic [7:0]  rdval_q;
	logic        rej_q;

	logic        in_fire;
	logic        cfg_fire;
	mode_t       mode_in;

	assign mode_in  = mode_t'(mode);
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// APB: always ready, hour_address at index 0
	assign pready   = 1'b1;
	assign cfg_fire = psel && penable && pwrite;
	assign prdata   = (paddr[2] == REG_HOUR_ADDRESS) ? {24'd0, hour_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q <= HOUR_ADDRESS_RESET;
		end else if (cfg_fire && paddr[2] == REG_HOUR_ADDRESS) begin
			hour_q <= pwdata[7:0];
		end
	end

	// Next state and result of one beat
	always_comb begin
		phase_n    = phase_q;
		tx_n       = tx_q;
		rx_n       = rx_q;
		read_n     = read_q;
		hour_hit_n = hour_hit_q;
		last_n     = last_q;
		shown      = phase_q;
		np         = phase_q + 6'd1;
		done_n     = 1'b0;
		rej_n      = 1'b0;
		case (mode_in)
			MODE_WRITE, MODE_READ: begin
				if (phase_q != PH_IDLE) begin
					// Busy: drop the request, hold the phase
					rej_n = 1'b1;
				end else begin
					hour_hit_n = (reg_address == hour_q);
					read_n     = (mode_in == MODE_READ);
					rx_n       = 8'd0;
					if (mode_in == MODE_READ) begin
						tx_n = {8'd0, reg_address + 8'd1};
					end else begin
						tx_n = {dec_to_bcd(value), reg_address};
					end
					phase_n = PH_START;
					shown   = PH_START;
				end
			end
			MODE_TICK: begin
				if (phase_q != PH_IDLE) begin
					// Sample the answer on each clock rise of the data byte
					if (read_q && np >= PH_RX_FIRST && np <= PH_BIT_LAST && !np[0]) begin
						rx_n = {io_in, rx_q[7:1]};
					end
					if (np >= PH_LAST) begin
						if (read_q) begin
							last_n = bcd_to_dec(rx_n, hour_hit_q);
						end
						done_n  = 1'b1;
						phase_n = PH_IDLE;
						shown   = PH_LAST;
					end else begin
						phase_n = np;
						shown   = np;
					end
				end
			end
			default: begin
			end
		endcase

		// Pin levels for the phase shown on this beat
		offs    = shown - PH_BIT_FIRST;
		bit_idx = offs[4:1];
		pins_n  = '0;
		if (shown == PH_ENABLE || shown == PH_CLK_LOW) begin
			pins_n.ce = 1'b1;
		end else if (shown >= PH_BIT_FIRST && shown <= PH_BIT_LAST) begin
			pins_n.ce    = 1'b1;
			pins_n.sclk  = offs[0];
			pins_n.drive = !read_n || !bit_idx[3];
			pins_n.dout  = pins_n.drive && tx_n[bit_idx];
		end else if (shown == PH_CLK_HIGH) begin
			pins_n.ce   = 1'b1;
			pins_n.sclk = 1'b1;
		end else if (shown == PH_LAST) begin
			pins_n.sclk = 1'b1;
		end
	end

	// Commit state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tx_q       <= '0;
			rx_q       <= '0;
			read_q     <= 1'b0;
			hour_hit_q <= 1'b0;
			last_q     <= '0;
		end else if (in_fire) begin
			phase_q    <= phase_n;
			tx_q       <= tx_n;
			rx_q       <= rx_n;
			read_q     <= read_n;
			hour_hit_q <= hour_hit_n;
			last_q     <= last_n;
		end
	end

	// Output register: load on accept, empty when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pins_q  <= pins_n;
			busy_q  <= (phase_n != PH_IDLE);
			done_q  <= done_n;
			rdval_q <= last_n;
			rej_q   <= rej_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign chip_enable  = pins_q.ce;
	assign serial_clock = pins_q.sclk;
	assign io_out       = pins_q.dout;
	assign io_drive     = pins_q.drive;
	assign busy_res     = busy_q;
	assign done_res     = done_q;
	assign read_value   = rdval_q;
	assign rejected     = rej_q;

	// The sequencer never parks on the final phase
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_CLK_HIGH)
		else $error("phase beyond last stored value");

	// A start request while busy is flagged and leaves the phase alone
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && phase_q != PH_IDLE && (mode_in == MODE_WRITE || mode_in == MODE_READ)
		|=> rejected && $stable(phase_q))
		else $error("busy request not rejected");

	// Done ends the transaction
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !chip_enable)
		else $error("done while still busy");

	// The data line is quiet whenever the master does not drive it
	a_quiet_io: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !io_drive |-> !io_out)
		else $error("io_out set while not driving");

	// A tick from the clock-low phase raises the clock with enable still high
	a_last_edge: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && mode_in == MODE_TICK && phase_q == PH_CLK_LOW
		|=> chip_enable && serial_clock && busy_res)
		else $error("final clock edge missing");

endmodule
`default_nettype wire

// ===== verif/rtc_three_wire_bcd_access_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_three_wire_bcd_access_unit_test
// Self-checking bench for the three-wire RTC access unit: drives request and
// tick beats with random gaps and back-pressure, checks every pin beat
// against a directed table entry or a cycle-free model of the sequencer,
// and reprograms the hour command over APB between transfers.
// ----------------------------------------------------------------------------
module rtc_three_wire_bcd_access_unit_test;
	import rtcb_pkg::*;

	localparam int unsigned RANDOM_LIVE_BEATS = 1660;
	localparam int unsigned STALL_LIMIT       = 200;
	localparam int unsigned TICKS_PER_XFER    = 36;

	// One output beat, in port order
	typedef struct packed {
		logic       ce;
		logic       sclk;
		logic       dout;
		logic       drive;
		logic       busy;
		logic       done;
		logic [7:0] rval;
		logic       rej;
	} rtc_beat_t;

	// One row of the directed table; reps repeats the beat
	typedef struct {
		mode_t       m;
		logic [7:0]  addr;
		logic [6:0]  val;
		logic        io;
		int unsigned reps;
		bit          typed;
		rtc_beat_t   want;
	} stim_row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [2:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	mode_t       mode         = MODE_TICK;
	logic [7:0]  reg_address  = '0;
	logic [6:0]  value        = '0;
	logic        io_in        = 1'b0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic        chip_enable;
	logic        serial_clock;
	logic        io_out;
	logic        io_drive;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_value;
	logic        rejected;

	rtc_three_wire_bcd_access_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.reg_address  (reg_address),
		.value        (value),
		.io_in        (io_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chip_enable  (chip_enable),
		.serial_clock (serial_clock),
		.io_out       (io_out),
		.io_drive     (io_drive),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.read_value   (read_value),
		.rejected     (rejected)
	);

	// Sequencer shadow: the bench's own copy of phase, shifters and config
	logic [5:0]  seq_phase = PH_IDLE;
	logic [15:0] tx_bits   = '0;
	logic [7:0]  rx_bits   = '0;
	logic        read_op   = 1'b0;
	logic        hour_hit  = 1'b0;
	logic [7:0]  last_rd   = '0;
	logic [7:0]  hour_cfg  = HOUR_ADDRESS_RESET;

	rtc_beat_t   beats_due[$];
	stim_row_t   stim_table[$];
	int unsigned fail_count   = 0;
	int unsigned live_beats   = 0;
	int unsigned stall_cycles = 0;
	int unsigned ready_hold   = 0;
	bit          gappy        = 1'b1;
	bit          sink_gappy   = 1'b1;
	bit          calm         = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Advance the shadow sequencer by one input beat and return the pin beat
	// it must produce. The pins show the phase reached by this beat, so the
	// closing beat shows the last phase even though the state is idle again.
	function automatic rtc_beat_t advance_sequencer(mode_t m, logic [7:0] a,
			logic [6:0] v, logic io);
		rtc_beat_t  r;
		logic [5:0] shown;
		logic [5:0] np;
		logic [5:0] off;
		logic [6:0] wv;
		logic [6:0] tens;
		logic [6:0] ones;
		logic [7:0] dec_tens;
		logic       done;
		r     = '0;
		done  = 1'b0;
		shown = seq_phase;
		if (m == MODE_WRITE || m == MODE_READ) begin
			if (seq_phase != PH_IDLE) begin
				r.rej = 1'b1;
			end else begin
				hour_hit = (a == hour_cfg);
				read_op  = (m == MODE_READ);
				rx_bits  = '0;
				if (read_op) begin
					tx_bits = {8'h00, a + 8'd1};
				end else begin
					// values above 99 still split by ten; tens may exceed 9
					wv      = hour_hit ? (v & 7'h7f) : v;
					tens    = wv / 7'd10;
					ones    = wv % 7'd10;
					tx_bits = {tens[3:0], ones[3:0], a};
				end
				seq_phase = PH_START;
				shown     = PH_START;
			end
		end else if (m == MODE_TICK && seq_phase != PH_IDLE) begin
			np = seq_phase + 6'd1;
			// answer bits are taken on the clock-high phase of bits 8..15
			if (read_op && np >= PH_RX_FIRST && np <= PH_BIT_LAST && !np[0])
				rx_bits = {io, rx_bits[7:1]};
			if (np >= PH_LAST) begin
				np = PH_LAST;
				if (read_op) begin
					dec_tens = hour_hit ? {4'd0, rx_bits[7:4]} : {5'd0, rx_bits[6:4]};
					last_rd  = 8'(dec_tens * 8'd10 + {4'd0, rx_bits[3:0]});
				end
				done      = 1'b1;
				seq_phase = PH_IDLE;
			end else begin
				seq_phase = np;
			end
			shown = np;
		end
		if (shown == PH_ENABLE) begin
			r.ce = 1'b1;
		end else if (shown >= PH_BIT_FIRST && shown <= PH_BIT_LAST) begin
			off     = shown - PH_BIT_FIRST;
			r.ce    = 1'b1;
			r.sclk  = off[0];
			r.drive = !read_op || off[5:1] < 5'd8;
			r.dout  = r.drive && tx_bits[off[4:1]];
		end else if (shown == PH_CLK_LOW) begin
			r.ce = 1'b1;
		end else if (shown == PH_CLK_HIGH) begin
			r.ce   = 1'b1;
			r.sclk = 1'b1;
		end else if (shown == PH_LAST) begin
			r.sclk = 1'b1;
		end
		r.busy = (seq_phase != PH_IDLE);
		r.done = done;
		r.rval = last_rd;
		return r;
	endfunction

	function automatic rtc_beat_t quiet_beat(logic ce, logic sclk, logic busy, logic done,
			logic [7:0] rval, logic rej);
		rtc_beat_t r;
		r       = '0;
		r.ce    = ce;
		r.sclk  = sclk;
		r.busy  = busy;
		r.done  = done;
		r.rval  = rval;
		r.rej   = rej;
		return r;
	endfunction

	function automatic stim_row_t stim(mode_t m, logic [7:0] a, logic [6:0] v, logic io,
			int unsigned reps, bit typed = 1'b0, rtc_beat_t want = '0);
		stim_row_t s;
		s.m     = m;
		s.addr  = a;
		s.val   = v;
		s.io    = io;
		s.reps  = reps;
		s.typed = typed;
		s.want  = want;
		return s;
	endfunction

	function automatic string fmt_beat(rtc_beat_t b);
		return $sformatf("ce=%b sclk=%b dout=%b drive=%b busy=%b done=%b read=%0d rej=%b",
			b.ce, b.sclk, b.dout, b.drive, b.busy, b.done, b.rval, b.rej);
	endfunction

	function automatic void note_failure(string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $time, what);
	endfunction

	// Offer one input beat, hold it until accepted, then log the expected
	// output beat. Called in the step of the previous acceptance, so valid
	// stays high across back-to-back beats with a single assignment.
	task automatic send_beat(mode_t m, logic [7:0] a, logic [6:0] v, logic io,
			bit typed = 1'b0, rtc_beat_t want = '0);
		rtc_beat_t predicted;
		if (gappy && !calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		reg_address <= a;
		value       <= v;
		io_in       <= io;
		do @(posedge clk); while (!in_ready);
		// count only beats the sequencer acts on
		if ((m == MODE_TICK && seq_phase != PH_IDLE)
				|| ((m == MODE_WRITE || m == MODE_READ) && seq_phase == PH_IDLE))
			live_beats++;
		predicted = advance_sequencer(m, a, v, io);
		beats_due.push_back(typed ? want : predicted);
	endtask

	// Drain everything in flight, then write the hour command and read it back
	// as one back-to-back APB pair.
	task automatic reprogram_hour(logic [7:0] code);
		logic [31:0] readback;
		in_valid <= 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_HOUR_ADDRESS, 2'b00};
		pwdata  <= {24'd0, code};
		@(posedge clk) penable <= 1'b1;
		@(posedge clk);
		// the write lands at this edge; turn straight into the read setup
		hour_cfg = code;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk) penable <= 1'b1;
		@(negedge clk) readback = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback[7:0] !== code)
			note_failure($sformatf("hour_address readback %0d, wrote %0d",
				readback[7:0], code));
	endtask

	// Output monitor: compare each accepted beat with the oldest expectation.
	// Signals are read before this edge's updates land.
	always @(posedge clk) begin : out_check
		rtc_beat_t seen;
		rtc_beat_t due;
		if (arst_n && out_valid && out_ready) begin
			seen = {chip_enable, serial_clock, io_out, io_drive, busy_res, done_res,
				read_value, rejected};
			if (beats_due.size() == 0) begin
				note_failure($sformatf("unexpected beat: %s", fmt_beat(seen)));
			end else begin
				due = beats_due.pop_front();
				if (seen !== due)
					note_failure($sformatf("beat mismatch\n  want %s\n  got  %s",
						fmt_beat(due), fmt_beat(seen)));
			end
		end
	end

	// Receiver back-pressure: drop out_ready at random, with quiet
	// stretches whenever sink_gappy drops, and none once calm is set.
	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0)
			sink_gappy <= 1'($urandom_range(0, 1));
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (!out_ready) begin
			out_ready  <= 1'b1;
			ready_hold <= $urandom_range(0, 7);
		end else if (!calm && sink_gappy && $urandom_range(0, 3) == 0) begin
			out_ready  <= 1'b0;
			ready_hold <= $urandom_range(0, 3);
		end
	end

	// Watchdog: give up when no beat moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d beats outstanding",
				stall_cycles, beats_due.size());
			$display("== FAIL ==");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int unsigned r;
		int unsigned k;
		int unsigned txn;
		mode_t       m;
		logic [7:0]  a;
		logic [6:0]  v;

		// Directed table, run with the reset hour command (132).
		// Idle beats, a write with stray requests, hour and plain reads of all
		// ones, a read whose command wraps, an out-of-range write.
		stim_table.push_back(stim(MODE_TICK, 8'h00, 7'd0, 1'b0, 1, 1'b1,
			quiet_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0)));
		stim_table.push_back(stim(MODE_NONE, 8'hff, 7'd127, 1'b1, 1, 1'b1,
			quiet_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0)));
		stim_table.push_back(stim(MODE_WRITE, 8'h80, 7'd99, 1'b0, 1, 1'b1,
			quiet_beat(1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0)));
		stim_table.push_back(stim(MODE_WRITE, 8'h81, 7'd5, 1'b0, 1, 1'b1,
			quiet_beat(1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b1)));
		stim_table.push_back(stim(MODE_READ, 8'h82, 7'd0, 1'b1, 1, 1'b1,
			quiet_beat(1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b1)));
		stim_table.push_back(stim(MODE_NONE, 8'h83, 7'd1, 1'b0, 1, 1'b1,
			quiet_beat(1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0)));
		stim_table.push_back(stim(MODE_TICK, 8'h00, 7'd0, 1'b0, TICKS_PER_XFER - 1));
		stim_table.push_back(stim(MODE_TICK, 8'h00, 7'd0, 1'b0, 1, 1'b1,
			quiet_beat(1'b0, 1'b1, 1'b0, 1'b1, 8'd0, 1'b0)));
		stim_table.push_back(stim(MODE_TICK, 8'h00, 7'd0, 1'b1, 1, 1'b1,
			quiet_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0)));
		stim_table.push_back(stim(MODE_READ, 8'd132, 7'd0, 1'b1, 1, 1'b1,
			quiet_beat(1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0)));
		stim_table.push_back(stim(MODE_TICK, 8'h00, 7'd0, 1'b1, TICKS_PER_XFER - 1));
		stim_table.push_back(stim(MODE_TICK, 8'h00, 7'd0, 1'b1, 1, 1'b1,
			quiet_beat(1'b0, 1'b1, 1'b0, 1'b1, 8'd165, 1'b0)));
		stim_table.push_back(stim(MODE_TICK, 8'h00, 7'd0, 1'b0, 1, 1'b1,
			quiet_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'd165, 1'b0)));
		stim_table.push_back(stim(MODE_READ, 8'h00, 7'd0, 1'b1, 1));
		stim_table.push_back(stim(MODE_TICK, 8'h00, 7'd0, 1'b1, TICKS_PER_XFER - 1));
		stim_table.push_back(stim(MODE_TICK, 8'h00, 7'd0, 1'b1, 1, 1'b1,
			quiet_beat(1'b0, 1'b1, 1'b0, 1'b1, 8'd85, 1'b0)));
		stim_table.push_back(stim(MODE_READ, 8'hff, 7'd0, 1'b0, 1));
		stim_table.push_back(stim(MODE_TICK, 8'h00, 7'd0, 1'b0, TICKS_PER_XFER - 1));
		stim_table.push_back(stim(MODE_TICK, 8'h00, 7'd0, 1'b0, 1, 1'b1,
			quiet_beat(1'b0, 1'b1, 1'b0, 1'b1, 8'd0, 1'b0)));
		stim_table.push_back(stim(MODE_WRITE, 8'd132, 7'd99, 1'b0, 1));
		stim_table.push_back(stim(MODE_TICK, 8'h00, 7'd0, 1'b1, TICKS_PER_XFER));
		stim_table.push_back(stim(MODE_WRITE, 8'hff, 7'd127, 1'b1, 1));
		stim_table.push_back(stim(MODE_TICK, 8'h00, 7'd0, 1'b0, TICKS_PER_XFER));

		// Hold reset, then release it and let the design settle
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i])
			for (r = 0; r < stim_table[i].reps; r++)
				send_beat(stim_table[i].m, stim_table[i].addr, stim_table[i].val,
					stim_table[i].io, stim_table[i].typed, stim_table[i].want);

		// Random transfers: mostly complete start-plus-36-tick sequences with
		// random content, salted with idle noise and stray mid-transfer requests.
		// Reprogram the hour command every eight transfers: zero, all ones, then
		// random codes.
		txn = 0;
		while (live_beats < RANDOM_LIVE_BEATS) begin
			calm  = (live_beats + 200 > RANDOM_LIVE_BEATS);
			gappy = ($urandom_range(0, 2) != 0);
			if (txn % 8 == 0 && !calm)
				reprogram_hour(txn == 0 ? 8'h00 :
					(txn == 8 ? 8'hff : 8'($urandom_range(0, 255))));
			// idle noise: tick or mode three with nothing running
			if ($urandom_range(0, 3) == 0) begin
				m = $urandom_range(0, 1) ? MODE_TICK : MODE_NONE;
				send_beat(m, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
					1'($urandom_range(0, 1)));
			end
			m = $urandom_range(0, 1) ? MODE_READ : MODE_WRITE;
			a = ($urandom_range(0, 2) == 0) ? hour_cfg : 8'($urandom_range(0, 255));
			v = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(100, 127))
				: 7'($urandom_range(0, 99));
			send_beat(m, a, v, 1'($urandom_range(0, 1)));
			for (k = 0; k < TICKS_PER_XFER; k++) begin
				// stray request or mode three while busy
				if ($urandom_range(0, 11) == 0) begin
					m = mode_t'($urandom_range(1, 3));
					send_beat(m, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
						1'($urandom_range(0, 1)));
				end
				send_beat(MODE_TICK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
					1'($urandom_range(0, 1)));
			end
			txn++;
		end

		// Drop valid, let the output side drain, then allow a short tail
		in_valid <= 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
sv/rtcb_pkg.sv
sv/rtc_three_wire_bcd_access_unit.sv
verif/rtc_three_wire_bcd_access_unit_test.sv
